>>> hdl/set_assoc_cache_lru_lookup_top_macros.svh
// assertion macros for the set-associative lru lookup block
// no dependencies; taken in by the top level with an include
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent true implies consequent in the same cycle
`define SACL_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sacl check failed");
// antecedent true implies consequent in the next cycle
`define SACL_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sacl check failed");
`else
`define SACL_ASSERT_IMP(name, ck, rn, ante, cons)
`define SACL_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

>>> hdl/sacl_pkg.sv
// shared types and constants for the set-associative lru lookup block
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps

package sacl_pkg;

  // default geometry limits
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  // field widths
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [CFG_DATA_W-1:0] SET_BITS_RST    = 4'd8;
  localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RST = 4'd8;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_FILL
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_wr;     // write a zero row during the clearing sweep
    logic take;       // accept a transaction and read its set
    logic scan_init;  // start the oldest-stamp search at way 0
    logic scan_step;  // compare one more way in the search
    logic commit;     // write the row back and present the result
    logic from_scan;  // commit uses the searched victim
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;   // last row of the clearing sweep
    logic hit;        // valid way with matching tag
    logic free;       // an invalid way in use exists
    logic single;     // only one way in use
    logic scan_last;  // search is at the last way in use
  } ctrl_sts_t;

endpackage

>>> hdl/sacl_ram.sv
// generic simple dual-port ram with registered read
// no dependencies; one write port and one read port
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/sacl_ctrl.sv
// controller state machine for the set-associative lru lookup block
// depends on sacl_pkg for the state, command and status types
`timescale 1ns / 1ps

module sacl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  sacl_pkg::ctrl_sts_t   sts,
  output sacl_pkg::ctrl_cmd_t   cmd
);

  sacl_pkg::state_t state_r;
  sacl_pkg::state_t state_nxt;

  // state register, clearing sweep first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.take  = 1'b1;
          state_nxt = sacl_pkg::ST_LOOK;
        end
      end
      sacl_pkg::ST_LOOK: begin
        if (sts.hit || sts.free || sts.single) begin
          cmd.commit = 1'b1;
          state_nxt  = sacl_pkg::ST_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = sacl_pkg::ST_SCAN;
        end
      end
      sacl_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = sacl_pkg::ST_FILL;
        end
      end
      sacl_pkg::ST_FILL: begin
        cmd.commit    = 1'b1;
        cmd.from_scan = 1'b1;
        state_nxt     = sacl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sacl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/sacl_dp.sv
// datapath for the set-associative lru lookup block: config, set ram, compare, counters
// depends on sacl_pkg and sacl_ram
`timescale 1ns / 1ps

module sacl_dp #(
  parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sacl_pkg::ADDR_W-1:0]         in_addr,
  input  sacl_pkg::ctrl_cmd_t                 cmd,
  output sacl_pkg::ctrl_sts_t                 sts,
  output logic                                out_strobe,
  output logic                                out_hit,
  output logic [sacl_pkg::CNT_W-1:0]          out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]          out_miss_total
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
  localparam int LANE_W = 1 + sacl_pkg::TAG_W + sacl_pkg::STAMP_W;
  localparam int ROW_W  = MAX_WAYS * LANE_W;
  localparam logic [sacl_pkg::CNT_W-1:0] CNT_MAX = '1;

  // configuration registers
  logic [sacl_pkg::CFG_DATA_W-1:0] off_r;
  logic [sacl_pkg::CFG_DATA_W-1:0] setb_r;
  logic [sacl_pkg::CFG_DATA_W-1:0] ways_r;

  // transaction registers
  logic [sacl_pkg::TAG_W-1:0]   block_r;
  logic [SET_W-1:0]             set_r;
  logic [sacl_pkg::STAMP_W-1:0] clock_r;
  logic [SET_W-1:0]             clr_idx_r;
  logic [sacl_pkg::STAMP_W-1:0] oldest_r;
  logic [WAY_W-1:0]             victim_r;
  logic [WAY_W-1:0]             scan_idx_r;
  logic [sacl_pkg::CNT_W-1:0]   hit_cnt_r;
  logic [sacl_pkg::CNT_W-1:0]   miss_cnt_r;
  logic                         strobe_r;
  logic                         hit_r;

  // combinational
  logic [sacl_pkg::CFG_DATA_W-1:0] sb_eff;
  logic [WCNT_W-1:0]               ways_eff;
  logic [sacl_pkg::TAG_W-1:0]      block_nxt;
  logic [SET_W-1:0]                set_mask;
  logic [SET_W-1:0]                set_nxt;
  logic [ROW_W-1:0]                rd_row;
  logic [ROW_W-1:0]                row_new;
  logic [ROW_W-1:0]                wr_row;
  logic [SET_W-1:0]                wr_addr;
  logic                            lane_vld   [MAX_WAYS];
  logic [sacl_pkg::TAG_W-1:0]      lane_tag   [MAX_WAYS];
  logic [sacl_pkg::STAMP_W-1:0]    lane_stamp [MAX_WAYS];
  logic [MAX_WAYS-1:0]             hit_v;
  logic [MAX_WAYS-1:0]             free_v;
  logic [WAY_W-1:0]                hit_way;
  logic [WAY_W-1:0]                free_way;
  logic [WAY_W-1:0]                direct_way;
  logic [WAY_W-1:0]                target;
  logic [LANE_W-1:0]               new_lane;
  logic                            hit_any;
  logic                            free_any;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= sacl_pkg::OFFSET_BITS_RST;
      setb_r <= sacl_pkg::SET_BITS_RST;
      ways_r <= sacl_pkg::WAYS_IN_USE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        sacl_pkg::CFG_OFFSET_BITS: off_r  <= cfg_data;
        sacl_pkg::CFG_SET_BITS:    setb_r <= cfg_data;
        sacl_pkg::CFG_WAYS_IN_USE: ways_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // effective geometry
  always_comb begin
    sb_eff = (setb_r > sacl_pkg::CFG_DATA_W'(SMAX)) ? sacl_pkg::CFG_DATA_W'(SMAX) : setb_r;
    if (ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if ({1'b0, ways_r} > (sacl_pkg::CFG_DATA_W + 1)'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_r);
    end
  end

  // block address and set index of the incoming address
  always_comb begin
    block_nxt = in_addr >> off_r;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (5'(i) < {1'b0, sb_eff});
    end
    set_nxt = block_nxt[SET_W-1:0] & set_mask;
  end

  // transaction capture and access clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
    end else if (cmd.take) begin
      clock_r <= clock_r + sacl_pkg::STAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      block_r <= block_nxt;
      set_r   <= set_nxt;
    end
  end

  // clearing sweep row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx_r <= clr_idx_r + SET_W'(1);
    end
  end

  // unpack the set row: valid, tag, stamp per way
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      {lane_vld[w], lane_tag[w], lane_stamp[w]} = rd_row[w*LANE_W +: LANE_W];
    end
  end

  // tag compare and free-way detect over the ways in use
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_v[w]  = (WCNT_W'(w) < ways_eff) && lane_vld[w] && (lane_tag[w] == block_r);
      free_v[w] = (WCNT_W'(w) < ways_eff) && !lane_vld[w];
    end
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_v[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_v[w]) begin
        free_way = WAY_W'(w);
      end
    end
    hit_any    = |hit_v;
    free_any   = |free_v;
    direct_way = hit_any ? hit_way : (free_any ? free_way : '0);
  end

  // oldest-stamp search, one way per cycle, lowest way wins a tie
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      oldest_r   <= lane_stamp[0];
      victim_r   <= '0;
      scan_idx_r <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (lane_stamp[scan_idx_r] < oldest_r) begin
        oldest_r <= lane_stamp[scan_idx_r];
        victim_r <= scan_idx_r;
      end
      scan_idx_r <= scan_idx_r + WAY_W'(1);
    end
  end

  // row write-back: target way gets valid, tag and fresh stamp; zero row when clearing
  always_comb begin
    target   = cmd.from_scan ? victim_r : direct_way;
    new_lane = {1'b1, block_r, clock_r};
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_new[w*LANE_W +: LANE_W] = (WAY_W'(w) == target) ? new_lane
                                                           : rd_row[w*LANE_W +: LANE_W];
    end
    wr_row  = cmd.clr_wr ? '0 : row_new;
    wr_addr = cmd.clr_wr ? clr_idx_r : set_r;
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_set_ram (
    .clk     (clk),
    .wr_en   (cmd.clr_wr | cmd.commit),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (cmd.take),
    .rd_addr (set_nxt),
    .rd_data (rd_row)
  );

  // saturating hit and miss counters, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= cmd.commit;
      if (cmd.commit) begin
        if (hit_any) begin
          if (hit_cnt_r != CNT_MAX) begin
            hit_cnt_r <= hit_cnt_r + sacl_pkg::CNT_W'(1);
          end
        end else if (miss_cnt_r != CNT_MAX) begin
          miss_cnt_r <= miss_cnt_r + sacl_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r <= hit_any;
    end
  end

  // status to the controller
  always_comb begin
    sts.clr_last  = (clr_idx_r == SET_W'(MAX_SETS - 1));
    sts.hit       = hit_any;
    sts.free      = free_any;
    sts.single    = (ways_eff == WCNT_W'(1));
    sts.scan_last = ((WCNT_W'(scan_idx_r) + WCNT_W'(1)) == ways_eff);
  end

  assign out_strobe     = strobe_r;
  assign out_hit        = hit_r;
  assign out_hit_total  = hit_cnt_r;
  assign out_miss_total = miss_cnt_r;

endmodule

>>> hdl/set_assoc_cache_lru_lookup_top.sv
// top level of the set-associative lru lookup block
// depends on sacl_pkg, sacl_ctrl, sacl_dp and the assertion macro header
`timescale 1ns / 1ps
`include "set_assoc_cache_lru_lookup_top_macros.svh"

// Tag-only set-associative cache lookup with lru replacement. Raise start with an
// address while busy is low; one result follows per transaction on out_strobe for a
// single cycle, and the receiver cannot stall it. A hit, a miss that finds an
// invalid way, or any miss with a single way in use commits from the lookup state
// and returns to idle; a miss into a full set with w ways in use (ways_in_use
// taken as 1 when zero and as MAX_WAYS above it, w of 2 or more) also passes
// through the search and fill states, as the oldest stamp is searched one way per
// cycle out of the registered set row. After reset busy stays high while the set
// ram is cleared one row a cycle; configuration writes are taken at any time
// (cfg_ready is always high) but should only be made while the block is idle.
module set_assoc_cache_lru_lookup_top #(
  parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic [sacl_pkg::ADDR_W-1:0]      in_addr,
  output logic                             out_strobe,
  output logic                             out_hit,
  output logic [sacl_pkg::CNT_W-1:0]       out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]       out_miss_total
);

  sacl_pkg::ctrl_cmd_t cmd;
  sacl_pkg::ctrl_sts_t sts;

  // configuration writes never stall
  assign cfg_ready = 1'b1;

  sacl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sacl_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_addr        (in_addr),
    .cmd            (cmd),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

  // checks
  `SACL_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy)
  `SACL_ASSERT_NXT(a_strobe_gap, clk, rst_n, out_strobe, !out_strobe)
  `SACL_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `SACL_ASSERT_IMP(a_hit_keeps_miss, clk, rst_n, out_strobe && out_hit, $stable(out_miss_total))

endmodule

>>> sim/set_assoc_cache_lru_lookup_top_tb.sv
// self-checking testbench for the set-associative lru lookup block
// depends on sacl_pkg and set_assoc_cache_lru_lookup_top; predicts every lookup in-bench
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_top_tb;

  localparam int SHADOW_SETS   = sacl_pkg::MAX_SETS_DEF;
  localparam int SHADOW_WAYS   = sacl_pkg::MAX_WAYS_DEF;
  localparam int NUM_LINES     = SHADOW_SETS * SHADOW_WAYS;
  localparam int SET_LOG2_CAP  = $clog2(SHADOW_SETS + 1) - 1;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [sacl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                       hit;
    logic [sacl_pkg::CNT_W-1:0] hits;
    logic [sacl_pkg::CNT_W-1:0] misses;
  } lookup_outcome_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [sacl_pkg::ADDR_W-1:0]     in_addr = '0;
  logic                            out_strobe;
  logic                            out_hit;
  logic [sacl_pkg::CNT_W-1:0]      out_hit_total;
  logic [sacl_pkg::CNT_W-1:0]      out_miss_total;

  // queues between stimulus, driver and monitor
  logic [sacl_pkg::ADDR_W-1:0] addr_q[$];
  lookup_outcome_t             outcome_q[$];
  logic [sacl_pkg::ADDR_W-1:0] recent_q[$];

  // shadow of the tag store and counters
  bit                           line_ok[NUM_LINES];
  logic [sacl_pkg::TAG_W-1:0]   line_blk[NUM_LINES];
  logic [sacl_pkg::STAMP_W-1:0] line_age[NUM_LINES];
  logic [sacl_pkg::STAMP_W-1:0] tick_count = '0;
  logic [sacl_pkg::CNT_W-1:0]   hit_tally = '0;
  logic [sacl_pkg::CNT_W-1:0]   miss_tally = '0;
  logic [sacl_pkg::CFG_DATA_W-1:0] cur_offset = sacl_pkg::OFFSET_BITS_RST;
  logic [sacl_pkg::CFG_DATA_W-1:0] cur_set_bits = sacl_pkg::SET_BITS_RST;
  logic [sacl_pkg::CFG_DATA_W-1:0] cur_ways = sacl_pkg::WAYS_IN_USE_RST;

  int idle_pct = 0;
  int error_count = 0;
  int checked_count = 0;
  int geometry_count = 1;
  logic [sacl_pkg::TAG_W-1:0] hot_hi[2];
  logic [7:0]                 hot_set[4];

  set_assoc_cache_lru_lookup_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .in_addr       (in_addr),
    .out_strobe    (out_strobe),
    .out_hit       (out_hit),
    .out_hit_total (out_hit_total),
    .out_miss_total(out_miss_total)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // whole-run limit
  initial begin
    #2000000;
    $display("timeout with %0d lookups still outstanding", outcome_q.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // ways per set actually searched
  function automatic int ways_used();
    if (cur_ways == 0) return 1;
    if (cur_ways > SHADOW_WAYS) return SHADOW_WAYS;
    return int'(cur_ways);
  endfunction

  // lookup of one address against the shadow tag store, updating it
  function automatic lookup_outcome_t predict_access(input logic [sacl_pkg::ADDR_W-1:0] addr);
    logic [sacl_pkg::TAG_W-1:0]   blk;
    logic [sacl_pkg::STAMP_W-1:0] oldest;
    lookup_outcome_t              res;
    int sb, nw, base, victim, idx;
    bit matched;
    blk = addr >> cur_offset;
    sb = (cur_set_bits > SET_LOG2_CAP) ? SET_LOG2_CAP : int'(cur_set_bits);
    nw = ways_used();
    base = int'(blk & ((64'd1 << sb) - 64'd1)) * SHADOW_WAYS;
    tick_count = tick_count + 1'b1;
    matched = 1'b0;
    for (int w = 0; w < nw; w++) begin
      idx = base + w;
      if (line_ok[idx] && line_blk[idx] == blk) begin
        line_age[idx] = tick_count;
        matched = 1'b1;
        break;
      end
    end
    if (matched) begin
      if (hit_tally != '1) hit_tally = hit_tally + 1'b1;
    end else begin
      if (miss_tally != '1) miss_tally = miss_tally + 1'b1;
      // first invalid way, else oldest stamp with the lowest way on a tie
      victim = 0;
      oldest = '1;
      for (int w = 0; w < nw; w++) begin
        idx = base + w;
        if (!line_ok[idx]) begin
          victim = w;
          break;
        end
        if (line_age[idx] < oldest) begin
          oldest = line_age[idx];
          victim = w;
        end
      end
      line_ok[base + victim] = 1'b1;
      line_blk[base + victim] = blk;
      line_age[base + victim] = tick_count;
    end
    res.hit = matched;
    res.hits = hit_tally;
    res.misses = miss_tally;
    return res;
  endfunction

  // driver: presents queued addresses, records the prediction at acceptance
  always @(posedge clk) begin : drive_proc
    bit took;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        outcome_q.push_back(predict_access(in_addr));
        void'(addr_q.pop_front());
      end
      if (start && !took) begin
        // hold the transaction until the block takes it
      end else if (addr_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_addr <= addr_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compares each strobed result with the oldest prediction
  always @(posedge clk) begin : watch_proc
    lookup_outcome_t want;
    if (rst_n && out_strobe) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result strobed with no lookup outstanding");
      end else begin
        want = outcome_q.pop_front();
        checked_count++;
        if (out_hit !== want.hit)
          report_mismatch($sformatf("hit %0b, expected %0b", out_hit, want.hit));
        if (out_hit_total !== want.hits)
          report_mismatch($sformatf("hit_total %0d, expected %0d", out_hit_total, want.hits));
        if (out_miss_total !== want.misses)
          report_mismatch($sformatf("miss_total %0d, expected %0d",
                                    out_miss_total, want.misses));
      end
    end
  end

  // one register write on the configuration channel
  task automatic write_reg(input logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sacl_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sacl_pkg::CFG_OFFSET_BITS: cur_offset = val;
      sacl_pkg::CFG_SET_BITS:    cur_set_bits = val;
      sacl_pkg::CFG_WAYS_IN_USE: cur_ways = val;
      default: ;
    endcase
  endtask

  // let every queued transaction complete and the block settle
  task automatic drain();
    while (addr_q.size() > 0 || outcome_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // address mostly from a few hot sets and tags so sets fill and evict
  function automatic logic [sacl_pkg::ADDR_W-1:0] make_addr();
    logic [sacl_pkg::TAG_W-1:0]  blk;
    logic [sacl_pkg::ADDR_W-1:0] low_mask;
    int pick;
    low_mask = (64'd1 << cur_offset) - 64'd1;
    pick = $urandom_range(0, 99);
    if (pick < 10) return {$urandom, $urandom};
    if (pick < 35 && recent_q.size() > 0)
      return recent_q[$urandom_range(0, recent_q.size() - 1)]
             ^ ({$urandom, $urandom} & low_mask);
    blk = hot_hi[$urandom_range(0, 1)];
    blk[7:0] = hot_set[$urandom_range(0, 3)];
    blk[11:8] = 4'($urandom_range(0, ways_used() + 1));
    return (blk << cur_offset) | ({$urandom, $urandom} & low_mask);
  endfunction

  // one geometry with random traffic
  task automatic run_phase(input logic [sacl_pkg::CFG_DATA_W-1:0] off,
                           input logic [sacl_pkg::CFG_DATA_W-1:0] sb,
                           input logic [sacl_pkg::CFG_DATA_W-1:0] nw,
                           input int gap_pct, input int count);
    logic [sacl_pkg::ADDR_W-1:0] a;
    drain();
    write_reg(sacl_pkg::CFG_WAYS_IN_USE, nw);
    write_reg(sacl_pkg::CFG_OFFSET_BITS, off);
    write_reg(sacl_pkg::CFG_SET_BITS, sb);
    geometry_count++;
    hot_hi[0] = {$urandom, $urandom};
    hot_hi[1] = {$urandom, $urandom};
    hot_set[0] = 8'h00;
    hot_set[1] = 8'hFF;
    hot_set[2] = 8'($urandom);
    hot_set[3] = 8'($urandom);
    recent_q.delete();
    idle_pct = gap_pct;
    for (int i = 0; i < count; i++) begin
      a = make_addr();
      recent_q.push_back(a);
      if (recent_q.size() > 4) void'(recent_q.pop_front());
      addr_q.push_back(a);
    end
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < NUM_LINES; i++) begin
      line_ok[i] = 1'b0;
      line_blk[i] = '0;
      line_age[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, repeat hits, fill and evict set 0 at reset geometry
    addr_q.push_back(64'h0);
    addr_q.push_back('1);
    addr_q.push_back(64'h0);
    addr_q.push_back(64'h3F);
    for (int k = 1; k <= 9; k++) addr_q.push_back(64'(k) << 14);
    addr_q.push_back(64'h0);
    addr_q.push_back(64'(2) << 14);
    addr_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    addr_q.push_back(64'h5555_5555_5555_5555);
    addr_q.push_back('1);

    // random traffic across geometries, lines kept between them
    run_phase(4'd0, 4'd0, 4'd1, 0, 80);
    run_phase(4'd12, 4'd8, 4'd8, 81, 80);
    run_phase(4'd15, 4'd15, 4'd15, 0, 80);
    run_phase(4'd13, 4'd9, 4'd0, 27, 80);
    drain();
    write_reg(CFG_SPARE, 4'($urandom));
    run_phase(4'd4, 4'd3, 4'd4, 0, 80);
    run_phase(4'd6, 4'd1, 4'd2, 81, 80);
    run_phase(4'd9, 4'd8, 4'd9, 27, 80);
    run_phase(4'd6, 4'd8, 4'd8, 0, 80);
    drain();

    $display("%0d lookups checked over %0d geometries", checked_count, geometry_count);
    $display("predicted %0d hits and %0d misses", hit_tally, miss_tally);
    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
